// ----- rtl/hof_pkg.sv -----
// Shared types and constants of the Hampel outlier filter.
`timescale 1ns / 1ps
package hof_pkg;

    localparam int HW_W         = 4;
    localparam int THR_W        = 12;
    localparam int RUN_LENGTH_W = 16;
    localparam int REG_IDX_W    = 2;
    localparam int PADDR_W      = 4;
    localparam int PDATA_W      = 32;

    localparam int HALF_WINDOW_MAX = 15;

    localparam int         L_W         = 17;
    localparam logic [16:0] L_Q16      = 17'd97164;
    localparam int         SCALE_SHIFT = 24;

    localparam logic [REG_IDX_W-1:0] REG_HALF_WINDOW = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_THRESHOLD   = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_IMPUTE      = 2'd2;

    localparam logic [HW_W-1:0]  HALF_WINDOW_RESET = 4'd3;
    localparam logic [THR_W-1:0] THRESHOLD_RESET   = 12'd768;

    typedef struct packed {
        logic [HW_W-1:0]  half_window;
        logic [THR_W-1:0] threshold_q4_8;
        logic             impute_missing;
    } cfg_t;

    typedef struct packed {
        logic            miss;
        logic            last;
        logic [HW_W-1:0] k;
    } cmd_ctl_t;

endpackage

// ----- rtl/hof_if.sv -----
// Sample and result channel interfaces.
`timescale 1ns / 1ps
interface hof_sample_if #(parameter int SAMPLE_BITS = 24);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          sample_missing;
    logic                          column_last;

    modport source (output valid, sample, sample_missing, column_last, input ready);
    modport sink (input valid, sample, sample_missing, column_last, output ready);
endinterface

interface hof_result_if #(parameter int SAMPLE_BITS = 24);
    import hof_pkg::*;
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] value;
    logic                          value_missing;
    logic [RUN_LENGTH_W-1:0]       run_length;
    logic                          replaced;
    logic                          run_saturated;
    logic                          step_last;
    logic                          column_done;

    modport source (output valid, value, value_missing, run_length, replaced,
                    run_saturated, step_last, column_done, input ready);
    modport sink (input valid, value, value_missing, run_length, replaced,
                  run_saturated, step_last, column_done, output ready);
endinterface

// ----- rtl/hof_cfg.sv -----
// APB register file of the Hampel outlier filter.
`timescale 1ns / 1ps
module hof_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [hof_pkg::PADDR_W-1:0]   paddr,
    input  logic [hof_pkg::PDATA_W-1:0]   pwdata,
    output logic [hof_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    output hof_pkg::cfg_t                 cfg
);
    import hof_pkg::*;

    cfg_t                 cfg_reg;
    cfg_t                 cfg_next;
    logic [REG_IDX_W-1:0] idx;

    assign idx    = paddr[PADDR_W-1:2];
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (psel && penable && pwrite)
        begin
            unique case (idx)
                REG_HALF_WINDOW: cfg_next.half_window    = pwdata[HW_W-1:0];
                REG_THRESHOLD:   cfg_next.threshold_q4_8 = pwdata[THR_W-1:0];
                REG_IMPUTE:      cfg_next.impute_missing = pwdata[0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_HALF_WINDOW: prdata = PDATA_W'(cfg_reg.half_window);
            REG_THRESHOLD:   prdata = PDATA_W'(cfg_reg.threshold_q4_8);
            REG_IMPUTE:      prdata = PDATA_W'(cfg_reg.impute_missing);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.half_window    <= HALF_WINDOW_RESET;
            cfg_reg.threshold_q4_8 <= THRESHOLD_RESET;
            cfg_reg.impute_missing <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ----- rtl/hof_front.sv -----
// Front end: accepts samples, latches the column's half window, queues requests.
`timescale 1ns / 1ps
module hof_front #(
    parameter int SAMPLE_BITS = 24,
    parameter int K_LIMIT     = 15
) (
    input  logic                          clk,
    input  logic                          rst_n,
    hof_sample_if.sink                    samples,
    input  logic [hof_pkg::HW_W-1:0]      half_window,
    output logic                          cmd_valid,
    output hof_pkg::cmd_ctl_t             cmd_ctl,
    output logic signed [SAMPLE_BITS-1:0] cmd_sample,
    input  logic                          cmd_pop
);
    import hof_pkg::*;

    localparam int DEPTH = 2;

    cmd_ctl_t                      ctl_reg [DEPTH];
    logic signed [SAMPLE_BITS-1:0] sample_reg [DEPTH];
    logic                          wr_ptr_reg, wr_ptr_next;
    logic                          rd_ptr_reg, rd_ptr_next;
    logic [1:0]                    count_reg, count_next;
    logic                          col_open_reg, col_open_next;
    logic [HW_W-1:0]               k_col_reg, k_col_next;
    logic [HW_W-1:0]               k_cap;
    logic                          push;
    cmd_ctl_t                      push_ctl;

    assign k_cap = (int'(half_window) > K_LIMIT) ? HW_W'(K_LIMIT) : half_window;

    assign samples.ready = (count_reg != 2'(DEPTH));
    assign push          = samples.valid && samples.ready;
    assign cmd_valid     = (count_reg != 2'd0);
    assign cmd_ctl       = ctl_reg[rd_ptr_reg];
    assign cmd_sample    = sample_reg[rd_ptr_reg];

    always_comb
    begin
        push_ctl.miss = samples.sample_missing;
        push_ctl.last = samples.column_last;
        push_ctl.k    = col_open_reg ? k_col_reg : k_cap;
        k_col_next    = k_col_reg;
        col_open_next = col_open_reg;
        wr_ptr_next   = wr_ptr_reg;
        rd_ptr_next   = rd_ptr_reg;
        count_next    = count_reg;
        if (push)
        begin
            k_col_next    = push_ctl.k;
            col_open_next = !samples.column_last;
            wr_ptr_next   = !wr_ptr_reg;
        end
        if (cmd_pop)
        begin
            rd_ptr_next = !rd_ptr_reg;
        end
        count_next = count_reg + 2'(push) - 2'(cmd_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ctl_reg[wr_ptr_reg]    <= push_ctl;
            sample_reg[wr_ptr_reg] <= samples.sample;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg   <= 1'b0;
            rd_ptr_reg   <= 1'b0;
            count_reg    <= 2'd0;
            col_open_reg <= 1'b0;
            k_col_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg   <= wr_ptr_next;
            rd_ptr_reg   <= rd_ptr_next;
            count_reg    <= count_next;
            col_open_reg <= col_open_next;
            k_col_reg    <= k_col_next;
        end
    end

endmodule

// ----- rtl/hof_hampel.sv -----
// Hampel test: bit-serial median and MAD selection, then the scaled threshold compare.
`timescale 1ns / 1ps
module hof_hampel #(
    parameter int SAMPLE_BITS = 24,
    parameter int WIN         = 31
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic signed [SAMPLE_BITS-1:0] win [WIN],
    input  logic [hof_pkg::HW_W-1:0]      k,
    input  logic [hof_pkg::THR_W-1:0]     threshold,
    output logic                          done,
    output logic signed [SAMPLE_BITS-1:0] value,
    output logic                          replaced
);
    import hof_pkg::*;

    localparam int DW = SAMPLE_BITS + 1;
    localparam int CW = $clog2(WIN + 1);
    localparam int SW = $clog2(DW);
    localparam int IW = (WIN > 1) ? $clog2(WIN) : 1;
    localparam int MW = THR_W + L_W;
    localparam int PW = MW + DW;

    typedef enum logic [5:0] {
        H_IDLE = 6'b000001,
        H_MED  = 6'b000010,
        H_DEV  = 6'b000100,
        H_MAD  = 6'b001000,
        H_MUL  = 6'b010000,
        H_CMP  = 6'b100000
    } h_state_t;

    h_state_t                      state_reg, state_next;
    logic [DW-1:0]                 work_reg [WIN];
    logic [DW-1:0]                 work_next [WIN];
    logic [WIN-1:0]                alive_reg, alive_next;
    logic [CW-1:0]                 rank_reg, rank_next;
    logic [DW-1:0]                 res_reg, res_next;
    logic [SW-1:0]                 step_reg, step_next;
    logic signed [SAMPLE_BITS-1:0] med_reg, med_next;
    logic [DW-1:0]                 dc_reg, dc_next;
    logic [MW-1:0]                 tl_reg, tl_next;
    logic [DW-1:0]                 mad_reg, mad_next;
    logic [PW-1:0]                 rhs_reg, rhs_next;
    logic                          done_reg, done_next;
    logic signed [SAMPLE_BITS-1:0] value_reg, value_next;
    logic                          repl_reg, repl_next;

    logic [CW-1:0]                 cnt0;
    logic                          take1;
    logic [DW-1:0]                 res_shift;
    logic signed [SAMPLE_BITS-1:0] centre;
    logic signed [DW-1:0]          dif;
    logic signed [DW-1:0]          cdif;
    logic                          repl;

    assign centre   = win[IW'(k)];
    assign done     = done_reg;
    assign value    = value_reg;
    assign replaced = repl_reg;

    always_comb
    begin
        cnt0 = '0;
        for (int j = 0; j < WIN; j++)
        begin
            cnt0 = cnt0 + CW'(alive_reg[j] & ~work_reg[j][DW-1]);
        end
        take1     = (rank_reg >= cnt0);
        res_shift = {res_reg[DW-2:0], take1};
    end

    always_comb
    begin
        state_next = state_reg;
        alive_next = alive_reg;
        rank_next  = rank_reg;
        res_next   = res_reg;
        step_next  = step_reg;
        med_next   = med_reg;
        dc_next    = dc_reg;
        tl_next    = tl_reg;
        mad_next   = mad_reg;
        rhs_next   = rhs_reg;
        done_next  = 1'b0;
        value_next = value_reg;
        repl_next  = repl_reg;
        dif        = '0;
        cdif       = '0;
        repl       = 1'b0;
        for (int j = 0; j < WIN; j++)
        begin
            work_next[j] = work_reg[j];
        end
        unique case (state_reg)
            H_IDLE:
            begin
                if (start)
                begin
                    for (int j = 0; j < WIN; j++)
                    begin
                        work_next[j]  = {~win[j][SAMPLE_BITS-1], win[j][SAMPLE_BITS-2:0], 1'b0};
                        alive_next[j] = (j <= 2 * int'(k));
                    end
                    rank_next  = CW'(k);
                    res_next   = '0;
                    step_next  = SW'(SAMPLE_BITS - 1);
                    tl_next    = MW'(threshold) * MW'(L_Q16);
                    state_next = H_MED;
                end
            end
            H_MED, H_MAD:
            begin
                for (int j = 0; j < WIN; j++)
                begin
                    alive_next[j] = alive_reg[j] & (work_reg[j][DW-1] == take1);
                    work_next[j]  = {work_reg[j][DW-2:0], 1'b0};
                end
                rank_next = take1 ? (rank_reg - cnt0) : rank_reg;
                res_next  = res_shift;
                step_next = step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    if (state_reg == H_MED)
                    begin
                        med_next   = {~res_shift[SAMPLE_BITS-1], res_shift[SAMPLE_BITS-2:0]};
                        state_next = H_DEV;
                    end
                    else
                    begin
                        mad_next   = res_shift;
                        state_next = H_MUL;
                    end
                end
            end
            H_DEV:
            begin
                for (int j = 0; j < WIN; j++)
                begin
                    dif           = DW'(win[j]) - DW'(med_reg);
                    work_next[j]  = dif[DW-1] ? DW'(-dif) : DW'(dif);
                    alive_next[j] = (j <= 2 * int'(k));
                end
                cdif       = DW'(centre) - DW'(med_reg);
                dc_next    = cdif[DW-1] ? DW'(-cdif) : DW'(cdif);
                rank_next  = CW'(k);
                res_next   = '0;
                step_next  = SW'(DW - 1);
                state_next = H_MAD;
            end
            H_MUL:
            begin
                rhs_next   = PW'(tl_reg) * PW'(mad_reg);
                state_next = H_CMP;
            end
            H_CMP:
            begin
                repl       = (PW'(dc_reg) << SCALE_SHIFT) > rhs_reg;
                repl_next  = repl;
                value_next = repl ? med_reg : centre;
                done_next  = 1'b1;
                state_next = H_IDLE;
            end
            default:
            begin
                state_next = H_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < WIN; j++)
        begin
            work_reg[j] <= work_next[j];
        end
        alive_reg <= alive_next;
        rank_reg  <= rank_next;
        res_reg   <= res_next;
        step_reg  <= step_next;
        med_reg   <= med_next;
        dc_reg    <= dc_next;
        tl_reg    <= tl_next;
        mad_reg   <= mad_next;
        rhs_reg   <= rhs_next;
        value_reg <= value_next;
        repl_reg  <= repl_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= H_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

endmodule

// ----- rtl/hof_back.sv -----
// Back end: window, pending NA runs, result sequencing and the output register.
`timescale 1ns / 1ps
module hof_back #(
    parameter int SAMPLE_BITS = 24,
    parameter int WIN         = 31,
    parameter int PD          = 16,
    parameter int RUN_MAX     = 65535
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    input  hof_pkg::cmd_ctl_t             cmd_ctl,
    input  logic signed [SAMPLE_BITS-1:0] cmd_sample,
    output logic                          cmd_pop,
    input  hof_pkg::cfg_t                 cfg,
    hof_result_if.source                  results
);
    import hof_pkg::*;

    localparam int IW    = (WIN > 1) ? $clog2(WIN) : 1;
    localparam int PCW   = $clog2(PD + 1);
    localparam int PIW   = (PD > 1) ? $clog2(PD) : 1;
    localparam int RUN_W = $clog2(RUN_MAX + 1);
    localparam int VSW   = $clog2(WIN + 1);

    typedef enum logic [6:0] {
        B_IDLE   = 7'b0000001,
        B_HSTART = 7'b0000010,
        B_HWAIT  = 7'b0000100,
        B_PASS   = 7'b0001000,
        B_EMITV  = 7'b0010000,
        B_EMITR  = 7'b0100000,
        B_FLUSH  = 7'b1000000
    } b_state_t;

    b_state_t                      state_reg, state_next;
    logic signed [SAMPLE_BITS-1:0] win_reg [WIN];
    logic signed [SAMPLE_BITS-1:0] win_next [WIN];
    logic [RUN_W-1:0]              cnt_reg [PD];
    logic [RUN_W-1:0]              cnt_next [PD];
    logic [PD-1:0]                 sat_reg, sat_next;
    logic [PCW-1:0]                pc_reg, pc_next;
    logic [VSW-1:0]                vs_reg, vs_next;
    logic signed [SAMPLE_BITS-1:0] last_out_reg, last_out_next;
    logic                          have_prev_reg, have_prev_next;
    cmd_ctl_t                      ctl_reg, ctl_next;
    logic signed [SAMPLE_BITS-1:0] cur_val_reg, cur_val_next;
    logic                          cur_repl_reg, cur_repl_next;
    logic [RUN_W-1:0]              run_cnt_reg, run_cnt_next;
    logic                          run_sat_reg, run_sat_next;

    logic                          out_valid_reg, out_valid_next;
    logic signed [SAMPLE_BITS-1:0] out_value_reg, out_value_next;
    logic                          out_missing_reg, out_missing_next;
    logic [RUN_LENGTH_W-1:0]       out_run_reg, out_run_next;
    logic                          out_repl_reg, out_repl_next;
    logic                          out_sat_reg, out_sat_next;
    logic                          out_step_reg, out_step_next;
    logic                          out_done_reg, out_done_next;

    logic                          out_free;
    logic                          h_start;
    logic                          h_done;
    logic signed [SAMPLE_BITS-1:0] h_value;
    logic                          h_repl;
    logic                          fill;
    logic                          step_end;

    assign out_free = !out_valid_reg || results.ready;
    assign fill     = cfg.impute_missing && have_prev_reg;

    hof_hampel #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .WIN         (WIN)
    ) u_hampel (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (h_start),
        .win       (win_reg),
        .k         (ctl_reg.k),
        .threshold (cfg.threshold_q4_8),
        .done      (h_done),
        .value     (h_value),
        .replaced  (h_repl)
    );

    always_comb
    begin
        state_next       = state_reg;
        sat_next         = sat_reg;
        pc_next          = pc_reg;
        vs_next          = vs_reg;
        last_out_next    = last_out_reg;
        have_prev_next   = have_prev_reg;
        ctl_next         = ctl_reg;
        cur_val_next     = cur_val_reg;
        cur_repl_next    = cur_repl_reg;
        run_cnt_next     = run_cnt_reg;
        run_sat_next     = run_sat_reg;
        out_valid_next   = out_valid_reg && !results.ready;
        out_value_next   = out_value_reg;
        out_missing_next = out_missing_reg;
        out_run_next     = out_run_reg;
        out_repl_next    = out_repl_reg;
        out_sat_next     = out_sat_reg;
        out_step_next    = out_step_reg;
        out_done_next    = out_done_reg;
        cmd_pop          = 1'b0;
        h_start          = 1'b0;
        step_end         = 1'b0;
        for (int j = 0; j < WIN; j++)
        begin
            win_next[j] = win_reg[j];
        end
        for (int j = 0; j < PD; j++)
        begin
            cnt_next[j] = cnt_reg[j];
        end
        unique case (state_reg)
            B_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop  = 1'b1;
                    ctl_next = cmd_ctl;
                    if (cmd_ctl.miss)
                    begin
                        if (pc_reg == '0)
                        begin
                            run_cnt_next = RUN_W'(1);
                            run_sat_next = 1'b0;
                            state_next   = B_EMITR;
                        end
                        else
                        begin
                            if (cnt_reg[PIW'(pc_reg - 1'b1)] < RUN_W'(RUN_MAX))
                            begin
                                cnt_next[PIW'(pc_reg - 1'b1)] =
                                    cnt_reg[PIW'(pc_reg - 1'b1)] + 1'b1;
                            end
                            else
                            begin
                                sat_next[PIW'(pc_reg - 1'b1)] = 1'b1;
                            end
                            state_next = B_FLUSH;
                        end
                    end
                    else
                    begin
                        for (int j = 1; j < WIN; j++)
                        begin
                            win_next[j] = win_reg[j-1];
                        end
                        win_next[0]             = cmd_sample;
                        cnt_next[PIW'(pc_reg)]  = '0;
                        sat_next[PIW'(pc_reg)]  = 1'b0;
                        pc_next                 = pc_reg + 1'b1;
                        if (vs_reg != VSW'(WIN))
                        begin
                            vs_next = vs_reg + 1'b1;
                        end
                        if (int'(pc_reg) >= int'(cmd_ctl.k))
                        begin
                            if (int'(vs_next) >= 2 * int'(cmd_ctl.k) + 1)
                            begin
                                state_next = B_HSTART;
                            end
                            else
                            begin
                                state_next = B_PASS;
                            end
                        end
                        else
                        begin
                            state_next = B_FLUSH;
                        end
                    end
                end
            end
            B_HSTART:
            begin
                h_start    = 1'b1;
                state_next = B_HWAIT;
            end
            B_HWAIT:
            begin
                if (h_done)
                begin
                    cur_val_next  = h_value;
                    cur_repl_next = h_repl;
                    state_next    = B_EMITV;
                end
            end
            B_PASS:
            begin
                cur_val_next  = win_reg[IW'(pc_reg - 1'b1)];
                cur_repl_next = 1'b0;
                state_next    = B_EMITV;
            end
            B_EMITV:
            begin
                if (out_free)
                begin
                    step_end         = (cnt_reg[0] == '0) && !(ctl_reg.last && pc_reg > PCW'(1));
                    out_valid_next   = 1'b1;
                    out_value_next   = cur_val_reg;
                    out_missing_next = 1'b0;
                    out_run_next     = RUN_LENGTH_W'(1);
                    out_repl_next    = cur_repl_reg;
                    out_sat_next     = 1'b0;
                    out_step_next    = step_end;
                    out_done_next    = step_end && ctl_reg.last;
                    last_out_next    = cur_val_reg;
                    have_prev_next   = 1'b1;
                    run_cnt_next     = cnt_reg[0];
                    run_sat_next     = sat_reg[0];
                    for (int j = 0; j < PD - 1; j++)
                    begin
                        cnt_next[j] = cnt_reg[j+1];
                        sat_next[j] = sat_reg[j+1];
                    end
                    cnt_next[PD-1] = '0;
                    sat_next[PD-1] = 1'b0;
                    pc_next        = pc_reg - 1'b1;
                    state_next     = (cnt_reg[0] != '0) ? B_EMITR : B_FLUSH;
                end
            end
            B_EMITR:
            begin
                if (out_free)
                begin
                    step_end         = !(ctl_reg.last && pc_reg != '0);
                    out_valid_next   = 1'b1;
                    out_value_next   = fill ? last_out_reg : '0;
                    out_missing_next = !fill;
                    out_run_next     = RUN_LENGTH_W'(run_cnt_reg);
                    out_repl_next    = 1'b0;
                    out_sat_next     = run_sat_reg;
                    out_step_next    = step_end;
                    out_done_next    = step_end && ctl_reg.last;
                    state_next       = B_FLUSH;
                end
            end
            B_FLUSH:
            begin
                if (ctl_reg.last && pc_reg != '0)
                begin
                    state_next = B_PASS;
                end
                else
                begin
                    if (ctl_reg.last)
                    begin
                        vs_next        = '0;
                        last_out_next  = '0;
                        have_prev_next = 1'b0;
                    end
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    assign results.valid         = out_valid_reg;
    assign results.value         = out_value_reg;
    assign results.value_missing = out_missing_reg;
    assign results.run_length    = out_run_reg;
    assign results.replaced      = out_repl_reg;
    assign results.run_saturated = out_sat_reg;
    assign results.step_last     = out_step_reg;
    assign results.column_done   = out_done_reg;

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < WIN; j++)
        begin
            win_reg[j] <= win_next[j];
        end
        ctl_reg         <= ctl_next;
        cur_val_reg     <= cur_val_next;
        cur_repl_reg    <= cur_repl_next;
        run_cnt_reg     <= run_cnt_next;
        run_sat_reg     <= run_sat_next;
        out_value_reg   <= out_value_next;
        out_missing_reg <= out_missing_next;
        out_run_reg     <= out_run_next;
        out_repl_reg    <= out_repl_next;
        out_sat_reg     <= out_sat_next;
        out_step_reg    <= out_step_next;
        out_done_reg    <= out_done_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            for (int j = 0; j < PD; j++)
            begin
                cnt_reg[j] <= '0;
            end
            sat_reg       <= '0;
            pc_reg        <= '0;
            vs_reg        <= '0;
            last_out_reg  <= '0;
            have_prev_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            for (int j = 0; j < PD; j++)
            begin
                cnt_reg[j] <= cnt_next[j];
            end
            sat_reg       <= sat_next;
            pc_reg        <= pc_next;
            vs_reg        <= vs_next;
            last_out_reg  <= last_out_next;
            have_prev_reg <= have_prev_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- rtl/hampel_outlier_filter_core.sv -----
// Top level of the streaming Hampel outlier filter.
//
// samples carries one row per request: sample, sample_missing, column_last.
// results carries one result per request: a valid sample (run_length 1), or
// a run of NA rows, with step_last on the last result of a row and
// column_done on the last result of a column.
// Registers sit on the APB port: half_window at 0x0, threshold_q4_8 at 0x4,
// impute_missing at 0x8; write them only while the block is idle.
// A two-entry queue decouples intake from processing, so up to two rows are
// taken while the back end is busy.
// Once 2k+1 valid samples of a column are seen, a valid row runs the
// bit-serial median and MAD selection, one bit per cycle over the whole
// window. At a column end the pending samples are flushed. Results lag
// their row by up to k valid samples. Reset empties the queue and all
// column state; registers take their defaults. A stalled receiver holds
// the output register and, in turn, the queue and the samples channel.
`timescale 1ns / 1ps
module hampel_outlier_filter_core #(
    parameter int K_MAX        = 15,
    parameter int WINDOW_DEPTH = 31,
    parameter int RUN_MAX      = 65535,
    parameter int SAMPLE_BITS  = 24
) (
    input  logic                        clk,
    input  logic                        rst_n,
    hof_sample_if.sink                  samples,
    hof_result_if.source                results,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [hof_pkg::PADDR_W-1:0] paddr,
    input  logic [hof_pkg::PDATA_W-1:0] pwdata,
    output logic [hof_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);
    import hof_pkg::*;

    localparam int KCAP = (K_MAX < (WINDOW_DEPTH - 1) / 2) ? K_MAX : (WINDOW_DEPTH - 1) / 2;
    localparam int KLIM = (KCAP < HALF_WINDOW_MAX) ? KCAP : HALF_WINDOW_MAX;
    localparam int WIN  = 2 * KLIM + 1;
    localparam int PD   = KLIM + 1;

    cfg_t                          cfg;
    logic                          cmd_valid;
    cmd_ctl_t                      cmd_ctl;
    logic signed [SAMPLE_BITS-1:0] cmd_sample;
    logic                          cmd_pop;

    hof_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    hof_front #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .K_LIMIT     (KLIM)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .samples     (samples),
        .half_window (cfg.half_window),
        .cmd_valid   (cmd_valid),
        .cmd_ctl     (cmd_ctl),
        .cmd_sample  (cmd_sample),
        .cmd_pop     (cmd_pop)
    );

    hof_back #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .WIN         (WIN),
        .PD          (PD),
        .RUN_MAX     (RUN_MAX)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_ctl    (cmd_ctl),
        .cmd_sample (cmd_sample),
        .cmd_pop    (cmd_pop),
        .cfg        (cfg),
        .results    (results)
    );

endmodule
